@@ rtl/rpbb_pkg.sv @@
// Package for the rotated point bounding box block.
// Holds the fixed-point widths, payload structs and register codes.
// No dependencies.
package rpbb_pkg;

  localparam int COORD_BITS = 24;
  localparam int COEF_BITS  = 16;
  localparam int COEF_FRAC  = COEF_BITS - 2;
  localparam int NUM_AXES   = 3;
  localparam int ROW_BITS   = NUM_AXES * COEF_BITS;
  localparam int PROD_BITS  = COORD_BITS + COEF_BITS;
  localparam int SUM_BITS   = PROD_BITS + 2;
  localparam int SHR_BITS   = SUM_BITS - COEF_FRAC;
  localparam int DATA_BITS  = 64;
  localparam int ADDR_BITS  = 5;
  localparam int IDX_LSB    = 3;

  typedef logic [ROW_BITS-1:0] row_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [ADDR_BITS-IDX_LSB-1:0] {
    REG_ROW0 = 2'd0,
    REG_ROW1 = 2'd1,
    REG_ROW2 = 2'd2
  } reg_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   last_point;
  } point_t;

  typedef struct packed {
    coord_t                centre_x;
    coord_t                centre_y;
    coord_t                centre_z;
    logic [COORD_BITS-1:0] extent_x;
    logic [COORD_BITS-1:0] extent_y;
    logic [COORD_BITS-1:0] extent_z;
  } box_t;

  // rotated point handed from the rotate pipeline to the bounds stage
  typedef struct packed {
    logic                  valid;
    logic                  last;
    coord_t [NUM_AXES-1:0] q;
  } rot_t;

endpackage

@@ rtl/rpbb_cfg.sv @@
// APB-style register file holding the three rotation matrix rows.
// Depends on rpbb_pkg.
module rpbb_cfg import rpbb_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_BITS-1:0]         paddr,
  input  logic [DATA_BITS-1:0]         pwdata,
  output logic [DATA_BITS-1:0]         prdata,
  output logic                         pready,
  output row_t [NUM_AXES-1:0]          rows
);

  logic [ADDR_BITS-IDX_LSB-1:0] idx;
  logic                         wr;

  assign idx    = paddr[ADDR_BITS-1:IDX_LSB];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= ROW_BITS'(1) << COEF_FRAC;
      rows[1] <= ROW_BITS'(1) << (COEF_FRAC + COEF_BITS);
      rows[2] <= ROW_BITS'(1) << (COEF_FRAC + 2 * COEF_BITS);
    end else if (wr) begin
      case (idx)
        REG_ROW0: rows[0] <= pwdata[ROW_BITS-1:0];
        REG_ROW1: rows[1] <= pwdata[ROW_BITS-1:0];
        REG_ROW2: rows[2] <= pwdata[ROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW0: prdata = DATA_BITS'(rows[0]);
      REG_ROW1: prdata = DATA_BITS'(rows[1]);
      REG_ROW2: prdata = DATA_BITS'(rows[2]);
      default:  prdata = '0;
    endcase
  end

endmodule

@@ rtl/rpbb_rotate.sv @@
// Rotation pipeline: input register, product register, rounded and
// saturated rotated point register. Depends on rpbb_pkg.
module rpbb_rotate import rpbb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                point_valid,
  input  point_t              point,
  input  row_t [NUM_AXES-1:0] rows,
  output rot_t                rot
);

  logic   s1_valid;
  point_t s1_pt;

  logic                        s2_valid;
  logic                        s2_last;
  logic signed [PROD_BITS-1:0] s2_prod [NUM_AXES][NUM_AXES];
  logic signed [PROD_BITS-1:0] prod_next [NUM_AXES][NUM_AXES];

  coord_t [NUM_AXES-1:0] q_next;

  always_comb begin
    coord_t                crd [NUM_AXES];
    logic signed [COEF_BITS-1:0] coef;
    crd[0] = s1_pt.point_x;
    crd[1] = s1_pt.point_y;
    crd[2] = s1_pt.point_z;
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        coef = $signed(rows[r][c*COEF_BITS +: COEF_BITS]);
        prod_next[r][c] = coef * crd[c];
      end
    end
  end

  always_comb begin
    logic signed [SUM_BITS-1:0] sum;
    logic signed [SHR_BITS-1:0] shr;
    logic signed [SHR_BITS-1:0] hi_lim;
    logic signed [SHR_BITS-1:0] lo_lim;
    hi_lim = $signed({{(SHR_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
    lo_lim = ~hi_lim;
    for (int r = 0; r < NUM_AXES; r++) begin
      sum = SUM_BITS'(s2_prod[r][0]) + SUM_BITS'(s2_prod[r][1])
          + SUM_BITS'(s2_prod[r][2]) + (SUM_BITS'(1) << (COEF_FRAC - 1));
      shr = $signed(sum[SUM_BITS-1:COEF_FRAC]);
      if (shr > hi_lim) begin
        q_next[r] = hi_lim[COORD_BITS-1:0];
      end else if (shr < lo_lim) begin
        q_next[r] = lo_lim[COORD_BITS-1:0];
      end else begin
        q_next[r] = shr[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rot.valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= point_valid;
      s2_valid  <= s1_valid;
      rot.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pt    <= point;
      s2_last  <= s1_pt.last_point;
      s2_prod  <= prod_next;
      rot.last <= s2_last;
      rot.q    <= q_next;
    end
  end

endmodule

@@ rtl/rpbb_bounds.sv @@
// Running min/max per axis and the result register with centre and extents.
// Depends on rpbb_pkg.
module rpbb_bounds import rpbb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  rot_t rot,
  input  logic box_stall,
  output logic adv,
  output logic box_valid,
  output box_t box
);

  logic                  started;
  coord_t [NUM_AXES-1:0] low;
  coord_t [NUM_AXES-1:0] high;
  coord_t [NUM_AXES-1:0] low_next;
  coord_t [NUM_AXES-1:0] high_next;
  coord_t [NUM_AXES-1:0] centre;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] extent;
  box_t                  box_next;
  logic                  emit;

  // only a last point waiting behind a stalled result holds the pipeline
  assign adv  = !(rot.valid && rot.last && box_valid && box_stall);
  assign emit = adv && rot.valid && rot.last;

  always_comb begin
    logic signed [COORD_BITS:0] sum;
    logic signed [COORD_BITS:0] diff;
    for (int a = 0; a < NUM_AXES; a++) begin
      low_next[a]  = (!started || rot.q[a] < low[a])  ? rot.q[a] : low[a];
      high_next[a] = (!started || rot.q[a] > high[a]) ? rot.q[a] : high[a];
      sum  = (COORD_BITS+1)'(high_next[a]) + (COORD_BITS+1)'(low_next[a]);
      diff = (COORD_BITS+1)'(high_next[a]) - (COORD_BITS+1)'(low_next[a]);
      centre[a] = sum[COORD_BITS:1];
      extent[a] = diff[COORD_BITS-1:0];
    end
    box_next.centre_x = centre[0];
    box_next.centre_y = centre[1];
    box_next.centre_z = centre[2];
    box_next.extent_x = extent[0];
    box_next.extent_y = extent[1];
    box_next.extent_z = extent[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      low       <= '0;
      high      <= '0;
      box_valid <= 1'b0;
    end else begin
      if (adv && rot.valid) begin
        low     <= low_next;
        high    <= high_next;
        started <= !rot.last;
      end
      if (emit) begin
        box_valid <= 1'b1;
      end else if (!box_stall) begin
        box_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      box <= box_next;
    end
  end

  a_emit_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(box_valid) |-> $past(rot.valid && rot.last))
    else $error("result raised without a last point");

  a_corner_order: assert property (@(posedge clk) disable iff (rst)
    started |-> (low[0] <= high[0] && low[1] <= high[1] && low[2] <= high[2]))
    else $error("low corner above high corner");

  a_new_set: assert property (@(posedge clk) disable iff (rst)
    emit |=> !started)
    else $error("set not restarted after last point");

endmodule

@@ rtl/rotated_point_bounding_box.sv @@
// Rotated point bounding box: takes one point per cycle, rotates it by the
// configured 3x3 Q2.14 matrix, saturates to Q12.12 and tracks the per-axis
// min/max of the set. A result (centre and extents) is presented after the
// point marked last is accepted and has passed the registers in order: the
// input register loads at the accepting edge, then the product, rotated-point
// and result registers. Points are taken every cycle; the input stalls only
// when a last point reaches the min/max stage while the previous result is
// still stalled at the output. Write the matrix only while the block is idle.
// Depends on rpbb_pkg, rpbb_cfg, rpbb_rotate, rpbb_bounds.
module rotated_point_bounding_box import rpbb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  input  logic                 point_valid,
  output logic                 point_stall,
  input  point_t               point,
  output logic                 box_valid,
  input  logic                 box_stall,
  output box_t                 box
);

  row_t [NUM_AXES-1:0] rows;
  rot_t                rot;
  logic                adv;

  assign point_stall = !adv;

  rpbb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rows    (rows)
  );

  rpbb_rotate u_rotate (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .point_valid (point_valid),
    .point       (point),
    .rows        (rows),
    .rot         (rot)
  );

  rpbb_bounds u_bounds (
    .clk       (clk),
    .rst       (rst),
    .rot       (rot),
    .box_stall (box_stall),
    .adv       (adv),
    .box_valid (box_valid),
    .box       (box)
  );

endmodule

@@ dv/tb_rotated_point_bounding_box.sv @@
// Testbench for rotated_point_bounding_box: hull point sets streamed in, boxes checked
// against an in-bench rotation and min/max tracker. Matrix rows written over APB.
// Depends on rpbb_pkg and the rotated_point_bounding_box RTL.
module tb_rotated_point_bounding_box;
  timeunit 1ns;
  timeprecision 1ps;
  import rpbb_pkg::*;

  localparam coord_t C_MAX = coord_t'(24'h7FFFFF);
  localparam coord_t C_MIN = coord_t'(24'h800000);
  localparam coord_t C_NEG1 = coord_t'(24'hFFFFFF);
  localparam logic [COORD_BITS-1:0] EXT_FULL = {COORD_BITS{1'b1}};
  localparam logic [COEF_BITS-1:0] K_ONE  = 16'h4000;
  localparam logic [COEF_BITS-1:0] K_NEG1 = 16'hC000;
  localparam logic [COEF_BITS-1:0] K_NEG2 = 16'h8000;
  localparam logic [COEF_BITS-1:0] K_MAX  = 16'h7FFF;
  localparam logic [COEF_BITS-1:0] K_TINY = 16'h0001;
  localparam logic [COEF_BITS-1:0] K_ZERO = 16'h0000;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_BLOCK    = 325;

  typedef enum {DO_POINT, DO_WRITE} plan_op_t;

  typedef struct {
    plan_op_t               op;
    logic [ADDR_BITS-1:0]   addr;
    logic [DATA_BITS-1:0]   data;
    point_t                 pt;
    bit                     known;
    box_t                   want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 point_valid = 1'b0;
  logic                 point_stall;
  point_t               point = '0;
  logic                 box_valid;
  logic                 box_stall = 1'b0;
  box_t                 box;

  // tracker state
  row_t   rot_matrix [NUM_AXES];
  longint box_lo [NUM_AXES];
  longint box_hi [NUM_AXES];
  bit     box_open;

  box_t      pending_boxes [$];
  plan_row_t directed_plan [$];
  int        errors = 0;
  int        send_idle = 27;
  int        recv_idle = 70;
  int        phase = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        quiet = 0;

  rotated_point_bounding_box dut (.*);

  always #5 clk = ~clk;

  function automatic logic [ADDR_BITS-1:0] addr_of(int idx);
    return ADDR_BITS'(idx << IDX_LSB);
  endfunction

  function automatic box_t mk_box(coord_t c, logic [COORD_BITS-1:0] e);
    return '{c, c, c, e, e, e};
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return C_MAX;
      1: return C_MIN;
      2, 3, 4: return coord_t'($urandom());
      default: return coord_t'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // rotate, saturate, fold into the running box; returns 1 when a box is due
  function automatic bit bound_point(point_t p, output box_t b);
    longint pt [NUM_AXES];
    longint acc, q, sat_hi, sat_lo;
    logic signed [COEF_BITS-1:0] k;
    coord_t cen [NUM_AXES];
    logic [COORD_BITS-1:0] ext [NUM_AXES];
    pt[0] = p.point_x;
    pt[1] = p.point_y;
    pt[2] = p.point_z;
    sat_hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    sat_lo = -sat_hi - 1;
    b = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      acc = 0;
      for (int c = 0; c < NUM_AXES; c++) begin
        k = rot_matrix[a][c*COEF_BITS +: COEF_BITS];
        acc += longint'(k) * pt[c];
      end
      acc += longint'(1) << (COEF_FRAC - 1);
      q = acc >>> COEF_FRAC;
      if (q > sat_hi) q = sat_hi;
      if (q < sat_lo) q = sat_lo;
      if (!box_open || q < box_lo[a]) box_lo[a] = q;
      if (!box_open || q > box_hi[a]) box_hi[a] = q;
    end
    box_open = 1'b1;
    if (!p.last_point) return 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      cen[a] = coord_t'((box_hi[a] + box_lo[a]) >>> 1);
      ext[a] = COORD_BITS'(box_hi[a] - box_lo[a]);
    end
    b = '{cen[0], cen[1], cen[2], ext[0], ext[1], ext[2]};
    box_open = 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_point(coord_t x, coord_t y, coord_t z, logic last,
                                    bit known = 1'b0, box_t want = '0);
    plan_row_t r;
    r.op = DO_POINT;
    r.addr = '0;
    r.data = '0;
    r.pt = '{x, y, z, last};
    r.known = known;
    r.want = want;
    directed_plan.push_back(r);
  endfunction

  function automatic void add_write(logic [ADDR_BITS-1:0] addr, logic [DATA_BITS-1:0] data);
    plan_row_t r;
    r.op = DO_WRITE;
    r.addr = addr;
    r.data = data;
    r.pt = '0;
    r.known = 1'b0;
    r.want = '0;
    directed_plan.push_back(r);
  endfunction

  task automatic send_point(point_t p, bit known, box_t want);
    box_t b;
    while ($urandom_range(0, 99) < send_idle) begin
      point_valid <= 1'b0;
      @(posedge clk);
    end
    point <= p;
    point_valid <= 1'b1;
    do @(posedge clk); while (point_stall);
    if (bound_point(p, b)) pending_boxes.push_back(known ? want : b);
  endtask

  // wait until every box is out and the pipeline has emptied
  task automatic settle();
    point_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [ADDR_BITS-1:0] addr, logic [DATA_BITS-1:0] data);
    int idx;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    idx = int'(addr >> IDX_LSB);
    if (idx < NUM_AXES) rot_matrix[idx] = data[ROW_BITS-1:0];
    @(posedge clk);
  endtask

  task automatic load_matrix();
    logic [COEF_BITS-1:0] k [NUM_AXES];
    int pick;
    pick = $urandom_range(0, 7);
    settle();
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        case (pick)
          0: k[c] = (r == c) ? K_ONE : K_ZERO;
          1: k[c] = K_NEG2;
          2: k[c] = K_MAX;
          3: k[c] = K_ZERO;
          default: begin
            if ($urandom_range(0, 9) < 2) k[c] = COEF_BITS'($urandom());
            else k[c] = COEF_BITS'(int'($urandom_range(0, 32768)) - 16384);
          end
        endcase
      end
      apb_write(addr_of(r), {16'($urandom()), k[2], k[1], k[0]});
    end
  endtask

  task automatic check_field(string name, logic [COORD_BITS-1:0] want,
                             logic [COORD_BITS-1:0] got);
    if (want !== got) begin
      $error("%s expected %06h got %06h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : box_check
    box_t want;
    if (!rst && box_valid && !box_stall) begin
      if (pending_boxes.size() == 0) begin
        $error("box word with no closed point set pending");
        errors++;
      end else begin
        want = pending_boxes.pop_front();
        check_field("centre_x", want.centre_x, box.centre_x);
        check_field("centre_y", want.centre_y, box.centre_y);
        check_field("centre_z", want.centre_z, box.centre_z);
        check_field("extent_x", want.extent_x, box.extent_x);
        check_field("extent_y", want.extent_y, box.extent_y);
        check_field("extent_z", want.extent_z, box.extent_z);
      end
    end
  end

  // output stall: one long hold-off once the no-idle phase starts sending
  always @(posedge clk) begin
    if (phase == 2 && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      box_stall <= 1'b1;
      hold_left--;
    end else begin
      box_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((point_valid && !point_stall) || (box_valid && !box_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_rotated_point_bounding_box failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int sent;
    int n;
    point_t pt;
    rot_matrix[0] = row_t'(K_ONE);
    rot_matrix[1] = row_t'(K_ONE) << COEF_BITS;
    rot_matrix[2] = row_t'(K_ONE) << (2 * COEF_BITS);
    for (int a = 0; a < NUM_AXES; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 0;
    end
    box_open = 1'b0;

    // identity matrix out of reset
    add_point(0, 0, 0, 1'b1, 1'b1, mk_box(0, 0));
    add_point(C_MAX, C_MAX, C_MAX, 1'b1, 1'b1, mk_box(C_MAX, 0));
    add_point(C_MIN, C_MIN, C_MIN, 1'b1, 1'b1, mk_box(C_MIN, 0));
    add_point(C_MAX, C_MAX, C_MAX, 1'b0);
    add_point(C_MIN, C_MIN, C_MIN, 1'b1, 1'b1, mk_box(C_NEG1, EXT_FULL));
    add_point(100, -200, 300, 1'b0);
    add_point(-5000, 7, 4096, 1'b0);
    add_point(12345, -12345, 1, 1'b1);
    // tiny and mixed coefficients, rounding at the half
    add_write(addr_of(REG_ROW0), {16'h0, K_ZERO, K_ZERO, K_TINY});
    add_write(addr_of(REG_ROW1), {16'h0, K_ONE, K_NEG2, K_MAX});
    add_write(addr_of(REG_ROW2), {16'h0, K_ZERO, K_NEG1, K_ZERO});
    add_point(8192, -8192, 8192, 1'b1);
    add_point(8191, -8193, 5, 1'b0);
    add_point(-8192, 8193, C_MAX, 1'b1);
    // all coefficients at -2.0: saturation both ways
    add_write(addr_of(REG_ROW0), {16'h0, K_NEG2, K_NEG2, K_NEG2});
    add_write(addr_of(REG_ROW1), {16'h0, K_NEG2, K_NEG2, K_NEG2});
    add_write(addr_of(REG_ROW2), {16'h0, K_NEG2, K_NEG2, K_NEG2});
    add_point(C_MAX, C_MAX, C_MAX, 1'b1, 1'b1, mk_box(C_MIN, 0));
    add_point(C_MIN, C_MIN, C_MIN, 1'b1, 1'b1, mk_box(C_MAX, 0));
    add_point(C_MAX, C_MAX, C_MAX, 1'b0);
    add_point(C_MIN, C_MIN, C_MIN, 1'b1, 1'b1, mk_box(C_NEG1, EXT_FULL));
    // write past the last row must not land
    add_write(addr_of(NUM_AXES), {16'h0, K_ONE, K_ONE, K_ONE});
    add_point(C_MAX, C_MAX, C_MAX, 1'b1, 1'b1, mk_box(C_MIN, 0));
    add_write(addr_of(REG_ROW0), {16'h0, K_MAX, K_MAX, K_MAX});
    add_write(addr_of(REG_ROW1), {16'h0, K_MAX, K_MAX, K_MAX});
    add_write(addr_of(REG_ROW2), {16'h0, K_MAX, K_MAX, K_MAX});
    add_point(C_MAX, C_MAX, C_MAX, 1'b1, 1'b1, mk_box(C_MAX, 0));
    add_point(1, 2, 3, 1'b1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].op == DO_WRITE) begin
        settle();
        apb_write(directed_plan[i].addr, directed_plan[i].data);
      end else begin
        send_point(directed_plan[i].pt, directed_plan[i].known, directed_plan[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 27 : (ph == 1) ? 70 : 0;
      recv_idle = (ph == 0) ? 70 : (ph == 1) ? 27 : 0;
      repeat (2) begin
        load_matrix();
        phase = ph;
        sent = 0;
        while (sent < PHASE_BLOCK) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            pt = '{rand_coord(), rand_coord(), rand_coord(), i == n - 1};
            send_point(pt, 1'b0, '0);
          end
          sent += n;
        end
      end
    end

    point_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_rotated_point_bounding_box passed");
    end else begin
      $display("tb_rotated_point_bounding_box failed");
    end
    $finish;
  end

endmodule
